### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked every clock outside of reset.
`define ART_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, checked outside of reset.
`define ART_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/core/art_pkg.sv
package art_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned PerW   = 16;
  localparam int unsigned TW     = 17;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned StepW  = 6;

  // Number of divider iterations for each job
  localparam logic [StepW-1:0] DivSteps  = 6'd32;
  localparam logic [StepW-1:0] FracSteps = 6'd17;

  // Smallest usable ramp length
  localparam logic [TimeW-1:0] MinRamp = 32'd2;

  // Config register indexes
  localparam logic [CfgIdxW-1:0] RegPeriod  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRunDur  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRampDur = 3'd2;
  localparam logic [CfgIdxW-1:0] RegReverse = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMode    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegLimit   = 3'd5;

  // Config reset values
  localparam logic [PerW-1:0]  PeriodRst  = 16'd40;
  localparam logic [TimeW-1:0] RunDurRst  = 32'd1000;
  localparam logic [TimeW-1:0] RampDurRst = 32'd1000;

  // Ramp modes
  localparam logic [ModeW-1:0] ModeOnce  = 2'd0;
  localparam logic [ModeW-1:0] ModeLoop  = 2'd1;
  localparam logic [ModeW-1:0] ModeSwing = 2'd2;

  // Q1.16 full scale
  localparam logic [TW-1:0] OneQ16 = 17'h10000;

  typedef struct packed {
    logic             start;
    logic [TimeW-1:0] rem_init;
    logic [TimeW-1:0] dividend;
    logic [TimeW-1:0] divisor;
    logic [StepW-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [TimeW-1:0] quot;
    logic [TimeW-1:0] rem;
  } div_rsp_t;

endpackage

### rtl/core/art_if.sv
// Tick input channel
interface art_in_if;
  logic                     valid;
  logic                     ready;
  logic [art_pkg::TimeW-1:0] now_ms;

  modport source (output valid, output now_ms, input ready);
  modport sink   (input valid, input now_ms, output ready);
endinterface

// Result channel
interface art_out_if;
  logic                   valid;
  logic                   ready;
  logic                   applied;
  logic                   first_call;
  logic                   finished;
  logic [art_pkg::TW-1:0] t_value;
  logic                   held;

  modport source (output valid, output applied, output first_call, output finished,
                  output t_value, output held, input ready);
  modport sink   (input valid, input applied, input first_call, input finished,
                  input t_value, input held, output ready);
endinterface

### rtl/core/art_div.sv
`include "assert_macros.svh"

// Restoring divider, one quotient bit per cycle. Dividend bits shift in MSB
// first behind a preloaded partial remainder.
module art_div (
  input  logic              clk,
  input  logic              rst_n,
  input  art_pkg::div_req_t req,
  output art_pkg::div_rsp_t rsp
);

  logic                              busy_r;
  logic                              done_r;
  logic [art_pkg::StepW-1:0]         cnt_r;
  logic [art_pkg::TimeW-1:0]         rem_r;
  logic [art_pkg::TimeW-1:0]         dvd_r;
  logic [art_pkg::TimeW-1:0]         den_r;
  logic [art_pkg::TimeW-1:0]         quot_r;
  logic [art_pkg::TimeW:0]           trial;
  logic [art_pkg::TimeW:0]           diff;
  logic                              ge;

  // Trial subtract of the shifted remainder
  assign trial = {rem_r, dvd_r[art_pkg::TimeW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == art_pkg::StepW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= req.rem_init;
      dvd_r  <= req.dividend;
      den_r  <= req.divisor;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[art_pkg::TimeW-1:0] : trial[art_pkg::TimeW-1:0];
      dvd_r  <= {dvd_r[art_pkg::TimeW-2:0], 1'b0};
      quot_r <= {quot_r[art_pkg::TimeW-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;

  `ART_ASSERT_IMP(a_rem_below_den, clk, rst_n, busy_r, rem_r < den_r, "remainder not below divisor")
  `ART_ASSERT_IMP(a_done_idle, clk, rst_n, done_r, !busy_r && $past(busy_r), "done without a run")

endmodule

### rtl/core/animation_ramp_timer.sv
// Channel   Dir  Signals                                    Transaction
// in_chan   in   valid ready now_ms                         one tick
// out_chan  out  valid ready applied first_call finished    one result per tick
//                t_value held
// cfg       in   cfg_we cfg_index cfg_wdata                 register write, no wait
//
// One tick at a time. A tick not applied, or held in once or unused mode, ends at
// evaluation; a hold on the limit ends after e/D; once mode runs only the fraction;
// loop and swing run both (serial divider: 32 steps for e/D, 17 for the Q1.16 fraction).
// Synchronous active-low reset; no clearing pass.
// A stalled result waits in the output register; the next tick is taken once
// that result has been loaded.
`include "assert_macros.svh"

module animation_ramp_timer (
  input  logic                         clk,
  input  logic                         rst_n,
  art_in_if.sink                       in_chan,
  art_out_if.source                    out_chan,
  input  logic                         cfg_we,
  input  logic [art_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [art_pkg::TimeW-1:0]    cfg_wdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TIME = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_DIVN = 3'd3;
  localparam logic [2:0] S_MOD  = 3'd4;
  localparam logic [2:0] S_FRAC = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  // Config registers
  logic [art_pkg::PerW-1:0]  period_r;
  logic [art_pkg::TimeW-1:0] run_dur_r;
  logic [art_pkg::TimeW-1:0] ramp_dur_r;
  logic                      reverse_r;
  logic [art_pkg::ModeW-1:0] mode_r;
  logic [art_pkg::TimeW-1:0] limit_r;

  // Run state
  logic                      started_r;
  logic [art_pkg::TimeW-1:0] start_r;
  logic [art_pkg::TimeW-1:0] last_apply_r;
  logic [art_pkg::TW-1:0]    last_t_r;

  // Per-tick work
  logic [2:0]                state_r, state_nxt;
  logic [art_pkg::TimeW-1:0] now_r;
  logic [art_pkg::TimeW-1:0] e_r;
  logic                      applied_r;
  logic                      first_r;
  logic                      finished_r;
  logic                      held_r;

  // Output register
  logic                      out_valid_r;
  logic                      out_applied_r;
  logic                      out_first_r;
  logic                      out_finished_r;
  logic [art_pkg::TW-1:0]    out_t_r;
  logic                      out_held_r;

  // Combinational helpers
  logic [art_pkg::TimeW-1:0] d_eff;
  logic [art_pkg::TimeW-1:0] half_d;
  logic [art_pkg::TimeW-1:0] since_apply;
  logic                      is_first;
  logic                      apply_now;
  logic [art_pkg::TimeW-1:0] frac_num;
  logic [art_pkg::TimeW-1:0] frac_den;
  logic                      mod_hold;
  logic                      eval_hold;
  logic                      out_load;
  logic                      div_wait;
  logic                      div_launch;
  art_pkg::div_req_t         div_req;
  art_pkg::div_rsp_t         div_rsp;

  assign d_eff  = (ramp_dur_r < art_pkg::MinRamp) ? art_pkg::MinRamp : ramp_dur_r;
  assign half_d = {1'b0, d_eff[art_pkg::TimeW-1:1]};

  // Tick gating
  assign is_first    = !started_r;
  assign since_apply = now_r - last_apply_r;
  assign apply_now   = is_first || (since_apply >= {16'd0, period_r});

  assign eval_hold = (mode_r == art_pkg::ModeOnce) ? (e_r > d_eff)
                   : !((mode_r == art_pkg::ModeLoop) || (mode_r == art_pkg::ModeSwing));
  assign mod_hold  = (limit_r != '0) && (div_rsp.quot >= limit_r);

  // Fraction operands for the current ramp segment
  always_comb begin
    frac_num = e_r;
    frac_den = d_eff;
    if (state_r == S_EVAL) begin
      frac_num = reverse_r ? (d_eff - e_r) : e_r;
    end else if (mode_r == art_pkg::ModeLoop) begin
      frac_num = reverse_r ? (d_eff - div_rsp.rem) : div_rsp.rem;
    end else if (div_rsp.rem <= half_d) begin
      frac_num = reverse_r ? (half_d - div_rsp.rem) : div_rsp.rem;
      frac_den = half_d;
    end else begin
      frac_num = reverse_r ? (div_rsp.rem - half_d) : (d_eff - div_rsp.rem);
      frac_den = d_eff - half_d;
    end
  end

  // Divider requests: e/D outside once mode, then floor(num * 2^16 / den) with num <= den
  always_comb begin
    div_req.start    = 1'b0;
    div_req.rem_init = {1'b0, frac_num[art_pkg::TimeW-1:1]};
    div_req.dividend = {frac_num[0], {(art_pkg::TimeW-1){1'b0}}};
    div_req.divisor  = frac_den;
    div_req.steps    = art_pkg::FracSteps;
    if (state_r == S_EVAL && applied_r && !eval_hold) begin
      div_req.start = 1'b1;
      if (mode_r != art_pkg::ModeOnce) begin
        div_req.rem_init = '0;
        div_req.dividend = e_r;
        div_req.divisor  = d_eff;
        div_req.steps    = art_pkg::DivSteps;
      end
    end else if (state_r == S_MOD && !mod_hold) begin
      div_req.start = 1'b1;
    end
  end

  art_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_chan.valid) state_nxt = S_TIME;
      S_TIME: state_nxt = S_EVAL;
      S_EVAL: begin
        if (!applied_r || eval_hold)           state_nxt = S_DONE;
        else if (mode_r == art_pkg::ModeOnce)  state_nxt = S_FRAC;
        else                                   state_nxt = S_DIVN;
      end
      S_DIVN: if (div_rsp.done) state_nxt = S_MOD;
      S_MOD:  state_nxt = mod_hold ? S_DONE : S_FRAC;
      S_FRAC: if (div_rsp.done) state_nxt = S_DONE;
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      started_r    <= 1'b0;
      start_r      <= '0;
      last_apply_r <= '0;
      last_t_r     <= '0;
      out_valid_r  <= 1'b0;
      period_r     <= art_pkg::PeriodRst;
      run_dur_r    <= art_pkg::RunDurRst;
      ramp_dur_r   <= art_pkg::RampDurRst;
      reverse_r    <= 1'b0;
      mode_r       <= art_pkg::ModeOnce;
      limit_r      <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          art_pkg::RegPeriod:  period_r   <= cfg_wdata[art_pkg::PerW-1:0];
          art_pkg::RegRunDur:  run_dur_r  <= cfg_wdata;
          art_pkg::RegRampDur: ramp_dur_r <= cfg_wdata;
          art_pkg::RegReverse: reverse_r  <= cfg_wdata[0];
          art_pkg::RegMode:    mode_r     <= cfg_wdata[art_pkg::ModeW-1:0];
          art_pkg::RegLimit:   limit_r    <= cfg_wdata;
          default: ;
        endcase
      end

      if (state_r == S_TIME && apply_now) begin
        started_r    <= 1'b1;
        last_apply_r <= now_r;
        if (is_first) start_r <= now_r;
      end

      if (state_r == S_FRAC && div_rsp.done) last_t_r <= div_rsp.quot[art_pkg::TW-1:0];

      if (out_load)             out_valid_r <= 1'b1;
      else if (out_chan.ready)  out_valid_r <= 1'b0;
    end
  end

  // Tick payload
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_chan.valid) now_r <= in_chan.now_ms;
    if (state_r == S_TIME) begin
      applied_r <= apply_now;
      first_r   <= is_first;
      held_r    <= 1'b0;
      e_r       <= is_first ? '0 : (now_r - start_r);
    end
    if (state_r == S_EVAL) begin
      finished_r <= (run_dur_r != '0) && (e_r > run_dur_r);
      if (applied_r && eval_hold) held_r <= 1'b1;
    end
    if (state_r == S_MOD && mod_hold) held_r <= 1'b1;
    if (out_load) begin
      out_applied_r  <= applied_r;
      out_first_r    <= first_r;
      out_finished_r <= finished_r;
      out_t_r        <= last_t_r;
      out_held_r     <= held_r;
    end
  end

  assign in_chan.ready       = (state_r == S_IDLE);
  assign out_chan.valid      = out_valid_r;
  assign out_chan.applied    = out_applied_r;
  assign out_chan.first_call = out_first_r;
  assign out_chan.finished   = out_finished_r;
  assign out_chan.t_value    = out_t_r;
  assign out_chan.held       = out_held_r;

  // States that wait on or launch the divider
  assign div_wait   = (state_r == S_DIVN) || (state_r == S_FRAC);
  assign div_launch = (state_r == S_EVAL) || (state_r == S_MOD);

  `ART_ASSERT(a_t_range, clk, rst_n, last_t_r <= art_pkg::OneQ16, "ramp value above full scale")
  `ART_ASSERT_IMP(a_div_done_state, clk, rst_n, div_rsp.done, div_wait, "stray divider done")
  `ART_ASSERT_IMP(a_div_start_state, clk, rst_n, div_req.start, div_launch, "stray divider start")
  `ART_ASSERT_IMP(a_started_after_tick, clk, rst_n, state_r == S_EVAL, started_r, "no run start")

endmodule
